// ===== rtl/core/tbnc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbnc_pkg
// Types and constants shared by the triangle backface / near-plane cull core.
// ----------------------------------------------------------------------------
`default_nettype none

package tbnc_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Z   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_DEPTH = 3'd3;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned CSR_DATA_W = COORD_W;

   // triangle state bits
   localparam int unsigned FLAG_ACTIVE   = 0;
   localparam int unsigned FLAG_BACKFACE = 1;
   localparam int unsigned FLAG_CLIPPED  = 2;

   // exact widths of the intermediate terms
   localparam int unsigned DIFF_W = COORD_W + 1;          // coordinate difference
   localparam int unsigned PROD_W = 2 * DIFF_W;           // cross product term
   localparam int unsigned NRM_W  = PROD_W + 1;           // normal component
   localparam int unsigned DOT_W  = NRM_W + DIFF_W;       // normal times view term
   localparam int unsigned SUM_W  = DOT_W + 2;            // full dot product

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
      logic [2:0]                tri_flags;
      logic                      two_sided;
   } req_type;

   typedef struct packed {
      logic [2:0] new_flags;
      logic       faces_away;
      logic       behind_near;
   } rsp_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } vec_diff_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] z;
   } vec_nrm_type;

   // per-triangle data that rides alongside the normal computation
   typedef struct packed {
      vec_diff_type w;
      logic [2:0]   flags;
      logic         tested;
      logic         behind;
   } side_type;

endpackage

`default_nettype wire

// ===== rtl/core/triangle_backface_near_cull_core.sv =====
// ----------------------------------------------------------------------------
// triangle_backface_near_cull_core
// Marks triangles that face away from the camera or reach the near plane.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid, req_stall, req_data      | in
//   result  | rsp_valid, rsp_stall, rsp_data      | out
//   config  | csr_write_en, csr_index, csr_write_data | in
//
// One triangle per clock when no result stall holds the pipeline.
// Five register stages: differences, cross products, normal, dot terms,
// dot sum and flags.
// Every stage has its own valid bit and moves when the next one has room,
// so bubbles are squeezed out under a result stall.
// Synchronous reset clears the valid bits and the camera / near registers.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_backface_near_cull_core
   import tbnc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic signed [COORD_W-1:0] camera_x_ff;
   logic signed [COORD_W-1:0] camera_y_ff;
   logic signed [COORD_W-1:0] camera_z_ff;
   logic signed [COORD_W-1:0] near_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff   <= '0;
         camera_y_ff   <= '0;
         camera_z_ff   <= '0;
         near_depth_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CAMERA_X:   camera_x_ff   <= csr_write_data;
            CSR_CAMERA_Y:   camera_y_ff   <= csr_write_data;
            CSR_CAMERA_Z:   camera_z_ff   <= csr_write_data;
            CSR_NEAR_DEPTH: near_depth_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en_1;
   logic en_4;
   logic en_out;
   logic nrm_in_ready;
   logic nrm_out_valid;

   // stage 1: edge vectors, view vector, near test
   logic         s1_valid_ff;
   vec_diff_type s1_u_ff;
   vec_diff_type s1_v_ff;
   side_type     s1_side_ff;
   vec_diff_type s1_u_in;
   vec_diff_type s1_v_in;
   side_type     s1_side_in;

   always_comb begin
      s1_u_in.x = DIFF_W'(req_data.v1_x) - DIFF_W'(req_data.v0_x);
      s1_u_in.y = DIFF_W'(req_data.v1_y) - DIFF_W'(req_data.v0_y);
      s1_u_in.z = DIFF_W'(req_data.v1_z) - DIFF_W'(req_data.v0_z);
      s1_v_in.x = DIFF_W'(req_data.v2_x) - DIFF_W'(req_data.v0_x);
      s1_v_in.y = DIFF_W'(req_data.v2_y) - DIFF_W'(req_data.v0_y);
      s1_v_in.z = DIFF_W'(req_data.v2_z) - DIFF_W'(req_data.v0_z);
      s1_side_in.w.x = DIFF_W'(camera_x_ff) - DIFF_W'(req_data.v0_x);
      s1_side_in.w.y = DIFF_W'(camera_y_ff) - DIFF_W'(req_data.v0_y);
      s1_side_in.w.z = DIFF_W'(camera_z_ff) - DIFF_W'(req_data.v0_z);
      s1_side_in.flags  = req_data.tri_flags;
      s1_side_in.tested = req_data.tri_flags[FLAG_ACTIVE]
                          && !req_data.tri_flags[FLAG_BACKFACE]
                          && !req_data.tri_flags[FLAG_CLIPPED]
                          && !req_data.two_sided;
      s1_side_in.behind = (req_data.v0_z <= near_depth_ff)
                          || (req_data.v1_z <= near_depth_ff)
                          || (req_data.v2_z <= near_depth_ff);
   end

   // stages 2 and 3: normal
   vec_nrm_type nrm_n;
   side_type    nrm_side;

   tbnc_normal u_normal (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (nrm_in_ready),
      .in_u      (s1_u_ff),
      .in_v      (s1_v_ff),
      .in_side   (s1_side_ff),
      .out_valid (nrm_out_valid),
      .out_ready (en_4),
      .out_n     (nrm_n),
      .out_side  (nrm_side)
   );

   // stage 4: normal times view, per axis
   logic                    s4_valid_ff;
   logic signed [DOT_W-1:0] s4_d_ff [3];
   logic signed [DOT_W-1:0] s4_d_in [3];
   side_type                s4_side_ff;

   always_comb begin
      s4_d_in[0] = DOT_W'(nrm_n.x) * DOT_W'(nrm_side.w.x);
      s4_d_in[1] = DOT_W'(nrm_n.y) * DOT_W'(nrm_side.w.y);
      s4_d_in[2] = DOT_W'(nrm_n.z) * DOT_W'(nrm_side.w.z);
   end

   // stage 5: dot sum, sign test, result register
   logic signed [SUM_W-1:0] dot_sum;
   logic                    faces;
   logic                    behind;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;

   always_comb begin
      dot_sum = SUM_W'(s4_d_ff[0]) + SUM_W'(s4_d_ff[1]) + SUM_W'(s4_d_ff[2]);
      faces   = s4_side_ff.tested && (dot_sum[SUM_W-1] || (dot_sum == '0));
      behind  = s4_side_ff.tested && s4_side_ff.behind;
      rsp_data_in.new_flags   = s4_side_ff.flags;
      rsp_data_in.faces_away  = faces;
      rsp_data_in.behind_near = behind;
      if (faces || behind) begin
         rsp_data_in.new_flags[FLAG_BACKFACE] = 1'b1;
      end
   end

   // a stage moves when it is empty or the stage after it moves
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_4      = !s4_valid_ff || en_out;
   assign en_1      = !s1_valid_ff || nrm_in_ready;
   assign req_stall = !en_1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_1) begin
            s1_valid_ff <= req_valid;
         end
         if (en_4) begin
            s4_valid_ff <= nrm_out_valid;
         end
         if (en_out) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_1) begin
         s1_u_ff    <= s1_u_in;
         s1_v_ff    <= s1_v_in;
         s1_side_ff <= s1_side_in;
      end
      if (en_4) begin
         s4_d_ff    <= s4_d_in;
         s4_side_ff <= nrm_side;
      end
      if (en_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // an empty result register means every stage can move
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while result register empty");

   a_marked_when_culled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.faces_away || rsp_data.behind_near)
      |-> rsp_data.new_flags[FLAG_BACKFACE])
      else $error("culled triangle without backface flag");

   a_cull_only_tested: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.faces_away || rsp_data.behind_near)
      |-> rsp_data.new_flags[FLAG_ACTIVE] && !rsp_data.new_flags[FLAG_CLIPPED])
      else $error("cull result on an untested triangle");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tbnc_normal.sv =====
// ----------------------------------------------------------------------------
// tbnc_normal
// Two-stage cross product n = u x v with exact products, valid/ready per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tbnc_normal
   import tbnc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire vec_diff_type in_u,
   input  wire vec_diff_type in_v,
   input  wire side_type     in_side,
   output logic              out_valid,
   input  wire logic         out_ready,
   output vec_nrm_type       out_n,
   output side_type          out_side
);

   logic en_a;
   logic en_b;

   // stage a: six products
   logic                     a_valid_ff;
   logic signed [PROD_W-1:0] a_p_ff [6];
   logic signed [PROD_W-1:0] a_p_in [6];
   side_type                 a_side_ff;

   // stage b: normal components
   logic        b_valid_ff;
   vec_nrm_type b_n_ff;
   vec_nrm_type b_n_in;
   side_type    b_side_ff;

   assign en_b     = !b_valid_ff || out_ready;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      a_p_in[0] = PROD_W'(in_u.y) * PROD_W'(in_v.z);
      a_p_in[1] = PROD_W'(in_u.z) * PROD_W'(in_v.y);
      a_p_in[2] = PROD_W'(in_u.z) * PROD_W'(in_v.x);
      a_p_in[3] = PROD_W'(in_u.x) * PROD_W'(in_v.z);
      a_p_in[4] = PROD_W'(in_u.x) * PROD_W'(in_v.y);
      a_p_in[5] = PROD_W'(in_u.y) * PROD_W'(in_v.x);
   end

   always_comb begin
      b_n_in.x = NRM_W'(a_p_ff[0]) - NRM_W'(a_p_ff[1]);
      b_n_in.y = NRM_W'(a_p_ff[2]) - NRM_W'(a_p_ff[3]);
      b_n_in.z = NRM_W'(a_p_ff[4]) - NRM_W'(a_p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= in_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_p_ff    <= a_p_in;
         a_side_ff <= in_side;
      end
      if (en_b) begin
         b_n_ff    <= b_n_in;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_n     = b_n_ff;
   assign out_side  = b_side_ff;

endmodule

`default_nettype wire
